// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define FFAR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define FFAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

// File: sv/ffar_pkg.sv
// Shared types, codes and constants of the fixed frame receiver with address filter.
package ffar_pkg;

   localparam int FRAME_LEN_DEFAULT = 16;

   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [1:0]            status_type;
   typedef logic [INDEX_W-1:0]    index_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Result status codes
   localparam status_type ST_IGNORED  = 2'd0;
   localparam status_type ST_STORED   = 2'd1;
   localparam status_type ST_REJECTED = 2'd2;
   localparam status_type ST_ACCEPTED = 2'd3;

   // Register indexes
   localparam csr_index_type REG_HEADER_BYTE = 2'd0;
   localparam csr_index_type REG_END_BYTE    = 2'd1;
   localparam csr_index_type REG_STATION     = 2'd2;

   // Register reset values
   localparam byte_type       HEADER_BYTE_RESET = 8'hFF;
   localparam byte_type       END_BYTE_RESET    = 8'hFC;
   localparam logic [15:0]    STATION_RESET     = 16'h0000;

endpackage

// File: sv/ffar_ifs.sv
// Valid/ready channel interfaces for received bytes and for result items.
interface ffar_req_if import ffar_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffar_rsp_if import ffar_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   byte_type   frame_byte;
   index_type  byte_index;
   logic       last;
   count_type  accepted_count;

   modport source (output valid, output status, output frame_byte, output byte_index,
                   output last, output accepted_count, input ready);
   modport sink   (input valid, input status, input frame_byte, input byte_index,
                   input last, input accepted_count, output ready);
endinterface

// File: sv/ffar_cell.sv
// One byte cell of the frame store chain: takes its neighbor's byte on shift.
module ffar_cell import ffar_pkg::*; (
   input  logic     clock,
   input  logic     shift_en,
   input  byte_type neighbor_byte,
   output byte_type cell_byte
);

   byte_type byte_ff;
   byte_type byte_in;

   assign byte_in   = shift_en ? neighbor_byte : byte_ff;
   assign cell_byte = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: sv/fixed_frame_receiver_addr_filter_unit.sv
// Top level of the fixed-length frame receiver with station address filter.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+-------------------------------------------
//   req_chan  | in  | valid/ready      | rx_byte
//   rsp_chan  | out | valid/ready      | status, frame_byte, byte_index, last,
//             |     |                  | accepted_count
//   csr_*     | in  | csr_wr_en only   | csr_index, csr_wdata
//
// Each received byte gives one result in the output register the next cycle.
// The byte that completes a good frame instead starts a drain: the frame leaves
// the cell chain one byte per cycle while the output is not stalled.
// Reset is synchronous and clears control state, the configuration registers
// and the output valid, not the cells or the output payload.
// A stalled output holds its item; a new byte is taken only while the output
// register is empty or its result leaves in the same cycle, and never during a drain.
module fixed_frame_receiver_addr_filter_unit import ffar_pkg::*; #(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ffar_req_if.sink      req_chan,
   ffar_rsp_if.source    rsp_chan,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_LEN - 1);

   // Configuration registers
   byte_type    header_ff, header_in;
   byte_type    end_ff, end_in;
   logic [15:0] station_ff, station_in;

   // Control state
   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] wr_pos_ff, wr_pos_in;
   logic             draining_ff, draining_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;
   count_type        count_ff, count_in;

   // Output register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   byte_type   out_byte_ff, out_byte_in;
   index_type  out_index_ff, out_index_in;
   logic       out_last_ff, out_last_in;
   count_type  out_count_ff, out_count_in;

   // Cell chain
   byte_type cell_q [FRAME_LEN];
   logic     shift_en;

   logic     out_free;
   logic     in_xfer;
   logic     drain_fire;
   logic     is_header;
   logic     frame_good;
   byte_type rx;

   assign rx       = req_chan.rx_byte;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !draining_ff && out_free;
   assign in_xfer    = req_chan.valid && req_chan.ready;
   assign drain_fire = draining_ff && out_free;
   assign is_header  = (rx == header_ff);

   // With FRAME_LEN-1 bytes stored, byte k sits in cell k+1.
   assign frame_good = (rx == end_ff) && (cell_q[3] == station_ff[15:8])
                       && (cell_q[4] == station_ff[7:0]);

   // Shift in a new byte while filling; shift toward cell 0 while draining.
   assign shift_en = (in_xfer && (in_frame_ff || is_header)) || drain_fire;

   for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cells
      if (g == FRAME_LEN - 1) begin : g_tail
         ffar_cell u_cell (
            .clock         (clock),
            .shift_en      (shift_en),
            .neighbor_byte (rx),
            .cell_byte     (cell_q[g])
         );
      end else begin : g_body
         ffar_cell u_cell (
            .clock         (clock),
            .shift_en      (shift_en),
            .neighbor_byte (cell_q[g+1]),
            .cell_byte     (cell_q[g])
         );
      end
   end

   // Configuration writes; unknown indexes fall through.
   always_comb begin
      header_in  = header_ff;
      end_in     = end_ff;
      station_in = station_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_HEADER_BYTE: header_in  = csr_wdata[7:0];
            REG_END_BYTE:    end_in     = csr_wdata[7:0];
            REG_STATION:     station_in = csr_wdata;
            default:         ;
         endcase
      end
   end

   // Frame tracking, drain sequencing and the output register.
   always_comb begin
      in_frame_in  = in_frame_ff;
      wr_pos_in    = wr_pos_ff;
      draining_in  = draining_ff;
      drain_idx_in = drain_idx_ff;
      count_in     = count_ff;

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;

      if (drain_fire) begin
         // Emit cell 0 and advance the burst.
         out_valid_in  = 1'b1;
         out_status_in = ST_ACCEPTED;
         out_byte_in   = cell_q[0];
         out_index_in  = INDEX_W'(drain_idx_ff);
         out_last_in   = (drain_idx_ff == LAST_POS);
         out_count_in  = count_ff;
         drain_idx_in  = drain_idx_ff + 1'b1;
         if (drain_idx_ff == LAST_POS) begin
            draining_in = 1'b0;
         end
      end else if (in_xfer) begin
         out_valid_in = 1'b1;
         out_byte_in  = '0;
         out_last_in  = 1'b1;
         out_count_in = count_ff;
         if (!in_frame_ff) begin
            out_index_in = '0;
            if (is_header) begin
               in_frame_in   = 1'b1;
               wr_pos_in     = IDX_W'(1);
               out_status_in = ST_STORED;
            end else begin
               out_status_in = ST_IGNORED;
            end
         end else if (wr_pos_ff == LAST_POS) begin
            in_frame_in = 1'b0;
            wr_pos_in   = '0;
            if (frame_good) begin
               // Hold off the result; the drain supplies the whole frame.
               out_valid_in = 1'b0;
               count_in     = count_ff + 1'b1;
               draining_in  = 1'b1;
               drain_idx_in = '0;
            end else begin
               out_status_in = ST_REJECTED;
               out_index_in  = INDEX_W'(LAST_POS);
            end
         end else begin
            wr_pos_in     = wr_pos_ff + 1'b1;
            out_status_in = ST_STORED;
            out_index_in  = INDEX_W'(wr_pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= HEADER_BYTE_RESET;
         end_ff       <= END_BYTE_RESET;
         station_ff   <= STATION_RESET;
         in_frame_ff  <= 1'b0;
         wr_pos_ff    <= '0;
         draining_ff  <= 1'b0;
         drain_idx_ff <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         end_ff       <= end_in;
         station_ff   <= station_in;
         in_frame_ff  <= in_frame_in;
         wr_pos_ff    <= wr_pos_in;
         draining_ff  <= draining_in;
         drain_idx_ff <= drain_idx_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_index_ff  <= out_index_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.frame_byte     = out_byte_ff;
   assign rsp_chan.byte_index     = out_index_ff;
   assign rsp_chan.last           = out_last_ff;
   assign rsp_chan.accepted_count = out_count_ff;

endmodule

// File: sv/ffar_checker.sv
// Port-level checks of the frame receiver and their bind to the top level.
`include "assert_macros.svh"

module ffar_checker import ffar_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input status_type rsp_status,
   input byte_type   rsp_frame_byte,
   input index_type  rsp_byte_index,
   input logic       rsp_last,
   input count_type  rsp_count
);

   // A stalled result holds.
   `FFAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_frame_byte) && $stable(rsp_byte_index) && $stable(rsp_count))

   // A frame burst runs without gaps once a byte of it is taken.
   `FFAR_ASSERT_NEXT(a_burst_gapless, rsp_valid && rsp_ready && rsp_status == ST_ACCEPTED && !rsp_last, rsp_valid && rsp_status == ST_ACCEPTED)

   // No byte is taken in while a burst is still pending.
   `FFAR_ASSERT_SAME(a_no_input_in_burst, rsp_valid && rsp_status == ST_ACCEPTED && !rsp_last, !req_ready)

   // Single results carry last and no frame byte.
   `FFAR_ASSERT_SAME(a_single_result, rsp_valid && rsp_status != ST_ACCEPTED, rsp_last && rsp_frame_byte == 8'h00)

endmodule

bind fixed_frame_receiver_addr_filter_unit ffar_checker u_ffar_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_frame_byte (rsp_chan.frame_byte),
   .rsp_byte_index (rsp_chan.byte_index),
   .rsp_last       (rsp_chan.last),
   .rsp_count      (rsp_chan.accepted_count)
);

// File: sim/fixed_frame_receiver_addr_filter_checker.sv
// Checker for the frame receiver: tracks its registers, predicts results and compares them.
module fixed_frame_receiver_addr_filter_checker import ffar_pkg::*; #(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ffar_req_if           req_mon,
   ffar_rsp_if           rsp_mon,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata,
   output int            fail_count,
   output int            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type status;
      byte_type   frame_byte;
      index_type  byte_index;
      logic       last;
      count_type  accepted_count;
   } frame_result_t;

   byte_type      header_cfg;
   byte_type      end_cfg;
   logic [15:0]   station_cfg;

   logic          in_frame;
   index_type     write_pos;
   byte_type      frame_cells [FRAME_LEN];
   count_type     frames_accepted;
   frame_result_t awaited_results [$];

   task automatic queue_result(status_type st, byte_type fb, index_type idx, logic lst);
      frame_result_t item;
      item.status         = st;
      item.frame_byte     = fb;
      item.byte_index     = idx;
      item.last           = lst;
      item.accepted_count = frames_accepted;
      awaited_results.push_back(item);
   endtask

   // Advance the receiver by one byte and queue every result it causes.
   task automatic receive_byte(byte_type b);
      bit frame_good;
      if (!in_frame) begin
         if (b == header_cfg) begin
            frame_cells[0] = b;
            in_frame       = 1'b1;
            write_pos      = index_type'(1);
            queue_result(ST_STORED, '0, '0, 1'b1);
         end else begin
            queue_result(ST_IGNORED, '0, '0, 1'b1);
         end
      end else begin
         frame_cells[write_pos] = b;
         if (write_pos == index_type'(FRAME_LEN - 1)) begin
            frame_good = (b == end_cfg) && (frame_cells[2] == station_cfg[15:8])
                         && (frame_cells[3] == station_cfg[7:0]);
            if (frame_good) begin
               frames_accepted = frames_accepted + 1'b1;
               for (int k = 0; k < FRAME_LEN; k++)
                  queue_result(ST_ACCEPTED, frame_cells[k], index_type'(k),
                               k == FRAME_LEN - 1);
            end else begin
               queue_result(ST_REJECTED, '0, index_type'(FRAME_LEN - 1), 1'b1);
            end
            in_frame  = 1'b0;
            write_pos = '0;
         end else begin
            queue_result(ST_STORED, '0, write_pos, 1'b1);
            write_pos = write_pos + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      frame_result_t exp_item;
      if (reset) begin
         header_cfg      = HEADER_BYTE_RESET;
         end_cfg         = END_BYTE_RESET;
         station_cfg     = STATION_RESET;
         in_frame        = 1'b0;
         write_pos       = '0;
         frames_accepted = '0;
         fail_count      = 0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_HEADER_BYTE: header_cfg  = csr_wdata[7:0];
               REG_END_BYTE:    end_cfg     = csr_wdata[7:0];
               REG_STATION:     station_cfg = csr_wdata[15:0];
               default: ;
            endcase
         end
         // Results at this edge belong to earlier bytes, so compare before predicting.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result with nothing awaited: status %0d byte_index %0d",
                      rsp_mon.status, rsp_mon.byte_index);
               fail_count++;
            end else begin
               exp_item = awaited_results.pop_front();
               if (rsp_mon.status !== exp_item.status) begin
                  $error("status: expected %0d, got %0d", exp_item.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.frame_byte !== exp_item.frame_byte) begin
                  $error("frame_byte: expected 0x%02h, got 0x%02h",
                         exp_item.frame_byte, rsp_mon.frame_byte);
                  fail_count++;
               end
               if (rsp_mon.byte_index !== exp_item.byte_index) begin
                  $error("byte_index: expected %0d, got %0d",
                         exp_item.byte_index, rsp_mon.byte_index);
                  fail_count++;
               end
               if (rsp_mon.last !== exp_item.last) begin
                  $error("last: expected %0d, got %0d", exp_item.last, rsp_mon.last);
                  fail_count++;
               end
               if (rsp_mon.accepted_count !== exp_item.accepted_count) begin
                  $error("accepted_count: expected %0d, got %0d",
                         exp_item.accepted_count, rsp_mon.accepted_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            receive_byte(req_mon.rx_byte);
      end
      outstanding = awaited_results.size();
   end

endmodule

// File: sim/fixed_frame_receiver_addr_filter_unit_test.sv
// Testbench top of the frame receiver: clock, reset, stimulus and verdict.
module fixed_frame_receiver_addr_filter_unit_test import ffar_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LEN = FRAME_LEN_DEFAULT;
   // Index with no register behind it; a write there must change nothing.
   localparam csr_index_type REG_SPARE = 2'd3;
   // Long enough for a good frame's drain, with margin on top.
   localparam int DRAIN_CYCLES = FRAME_LEN + 8;
   localparam int LONG_HOLD = 300;
   localparam int BYTES_PER_PHASE = 30;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   int            fail_count;
   int            outstanding;
   int            bytes_sent;
   int            req_idle_pct;
   int            rsp_idle_pct;
   int            hold_requests;
   int            holds_done;

   // Register values last written, used to build well-formed frames.
   byte_type      header_now;
   byte_type      end_now;
   logic [15:0]   station_now;

   ffar_req_if req_chan ();
   ffar_rsp_if rsp_chan ();

   fixed_frame_receiver_addr_filter_unit #(.FRAME_LEN(FRAME_LEN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fixed_frame_receiver_addr_filter_checker #(.FRAME_LEN(FRAME_LEN)) frame_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side: random ready, plus a long hold-off whenever one is requested.
   initial begin
      rsp_chan.ready = 1'b0;
      holds_done     = 0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            // Hold ready low and count the stretch here, while the sender keeps going.
            for (int c = 0; c < LONG_HOLD; c++) begin
               if (c > 0)
                  @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
            holds_done++;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // All tasks below start and end at a falling edge.
   task automatic send_byte(byte_type b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      // Wait for the transfer, then step to the next falling edge to drive again.
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Junk in the upper byte of the 8-bit registers checks that it is masked off.
   task automatic set_config(byte_type hdr, byte_type endb, logic [15:0] stn);
      write_reg(REG_HEADER_BYTE, {8'($urandom_range(255)), hdr});
      write_reg(REG_END_BYTE, {8'($urandom_range(255)), endb});
      write_reg(REG_STATION, stn);
      header_now  = hdr;
      end_now     = endb;
      station_now = stn;
   endtask

   // Drop valid, wait out every awaited result and any drain still running.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Well-formed frame with random body; now and then break the address or end byte.
   task automatic send_frame();
      byte_type cells [FRAME_LEN];
      foreach (cells[k])
         cells[k] = byte_type'($urandom_range(255));
      cells[0]             = header_now;
      cells[2]             = station_now[15:8];
      cells[3]             = station_now[7:0];
      cells[FRAME_LEN - 1] = end_now;
      case ($urandom_range(7))
         0: cells[2] ^= byte_type'($urandom_range(1, 255));
         1: cells[3] ^= byte_type'($urandom_range(1, 255));
         2: cells[FRAME_LEN - 1] ^= byte_type'($urandom_range(1, 255));
         default: ;
      endcase
      foreach (cells[k])
         send_byte(cells[k]);
   endtask

   // Stray bytes; a stray header byte opens a frame that the next bytes complete.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_byte(byte_type'($urandom_range(255)));
   endtask

   task automatic send_mix(int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         if ($urandom_range(9) < 7)
            send_frame();
         else
            send_noise();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_HEADER_BYTE;
      csr_wdata        = '0;
      bytes_sent       = 0;
      hold_requests    = 0;
      req_idle_pct     = 22;
      rsp_idle_pct     = 46;
      header_now       = HEADER_BYTE_RESET;
      end_now          = END_BYTE_RESET;
      station_now      = STATION_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Spare index: must leave the reset configuration untouched.
      write_reg(REG_SPARE, 16'hFFFF);

      // Directed: two ignored bytes, then a good frame under reset settings with
      // extreme byte values in the body.
      send_byte(8'h00);
      send_byte(8'h7E);
      send_byte(HEADER_BYTE_RESET);
      send_byte(8'hFF);
      send_byte(STATION_RESET[15:8]);
      send_byte(STATION_RESET[7:0]);
      for (int k = 4; k < FRAME_LEN - 1; k++)
         send_byte((k % 2) ? 8'hFF : 8'h00);
      send_byte(END_BYTE_RESET);
      wait_idle();

      // First idling pattern, extreme settings one way.
      set_config(8'h00, 8'hFF, 16'hFFFF);
      send_mix(BYTES_PER_PHASE);
      wait_idle();

      // Swap the idling, random settings.
      req_idle_pct = 46;
      rsp_idle_pct = 22;
      set_config(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)),
                 16'($urandom_range(65535)));
      send_mix(BYTES_PER_PHASE);
      wait_idle();

      // No idling, extremes the other way; start with a long receiver hold-off so the
      // block backs up and stalls its input.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_config(8'hFF, 8'h00, 16'h0000);
      hold_requests = 1;
      send_frame();
      send_frame();
      send_mix(BYTES_PER_PHASE);
      wait_idle();

      if (fail_count == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
